@@ rtl/core/tcfqs_pkg.sv @@
// Package: shared constants, types and the class decode for the three-class queue scheduler.
`default_nettype none

package tcfqs_pkg;

  // Storage geometry
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned JOB_WIDTH   = 64;
  localparam int unsigned JOB_PORT_W  = 64;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NUM_CLASSES = 3;

  // Budget reload values of the weighted round robin
  localparam logic [1:0] NORMAL_BUDGET_FULL = 2'd2;
  localparam logic [1:0] NORMAL_BUDGET_ONE  = 2'd1;
  localparam logic       LOW_BUDGET_ONE     = 1'b1;

  // Request priority codes
  localparam logic [1:0] PRIO_HIGH   = 2'd0;
  localparam logic [1:0] PRIO_NORMAL = 2'd1;
  localparam logic [1:0] PRIO_LOW    = 2'd2;
  localparam logic [1:0] PRIO_ALT    = 2'd3;

  typedef enum logic {
    OP_ENQ  = 1'b0,
    OP_RECV = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CLS_HIGH   = 2'd0,
    CLS_NORMAL = 2'd1,
    CLS_LOW    = 2'd2
  } cls_e;

  // Command handed from the front to the back
  typedef struct packed {
    op_e                  op;
    cls_e                 cls;
    logic [JOB_WIDTH-1:0] job;
  } cmd_t;

  // Map a request priority to its queue; the spare code lands in normal
  function automatic cls_e prio_to_cls(input logic [1:0] prio);
    cls_e cls;
    unique case (prio)
      PRIO_HIGH:   cls = CLS_HIGH;
      PRIO_LOW:    cls = CLS_LOW;
      PRIO_NORMAL: cls = CLS_NORMAL;
      PRIO_ALT:    cls = CLS_NORMAL;
      default:     cls = CLS_NORMAL;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tcfqs_front.sv @@
// Front end: accepts transactions, classifies them and buffers commands in a two-entry queue.
`default_nettype none

module tcfqs_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          mode_i,
  input  wire logic [1:0]                    priority_req_i,
  input  wire logic [63:0]                   job_in_i,
  output logic                               cmd_valid_o,
  input  wire logic                          cmd_ready_i,
  output tcfqs_pkg::cmd_t                    cmd_o
);
  import tcfqs_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_new;

  // Classify the incoming transaction
  always_comb begin
    cmd_new.op  = mode_i ? OP_RECV : OP_ENQ;
    cmd_new.cls = prio_to_cls(priority_req_i);
    cmd_new.job = job_in_i[JOB_WIDTH-1:0];
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  // Queue pointer and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Command slots, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tcfqs_back.sv @@
// Back end: three job FIFOs, the strict-priority plus weighted round-robin pick and the result register.
`default_nettype none

module tcfqs_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_ready_o,
  input  wire tcfqs_pkg::cmd_t               cmd_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               ok_o,
  output logic [63:0]                        job_out_o
);
  import tcfqs_pkg::*;

  logic [PTR_W-1:0]     head_q [NUM_CLASSES];
  logic [PTR_W-1:0]     tail_q [NUM_CLASSES];
  logic [CNT_W-1:0]     cnt_q  [NUM_CLASSES];
  logic [JOB_WIDTH-1:0] rd_data_q [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] not_empty, full;

  logic [1:0] nb_q, nb_d;
  logic       lb_q, lb_d;

  logic       out_valid_q;
  logic       out_ok_q;
  logic       out_rd_q;
  cls_e       out_cls_q;

  logic       fire;
  logic       push_en;
  logic       pop_en;
  cls_e       pop_cls;
  logic       op_ok;

  // Queue status
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      not_empty[c] = (cnt_q[c] != '0);
      full[c]      = (cnt_q[c] == CNT_W'(QUEUE_DEPTH));
    end
  end

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;

  // Pick the queue to serve and the budget updates
  always_comb begin
    push_en = 1'b0;
    pop_en  = 1'b0;
    pop_cls = CLS_HIGH;
    nb_d    = nb_q;
    lb_d    = lb_q;
    if (cmd_i.op == OP_ENQ) begin
      push_en = !full[cmd_i.cls];
    end else begin
      priority if (not_empty[CLS_HIGH]) begin
        pop_en  = 1'b1;
        pop_cls = CLS_HIGH;
      end else if (not_empty[CLS_NORMAL] && (nb_q != 2'd0)) begin
        pop_en  = 1'b1;
        pop_cls = CLS_NORMAL;
        nb_d    = nb_q - 2'd1;
        lb_d    = LOW_BUDGET_ONE;
      end else if (not_empty[CLS_LOW] && lb_q) begin
        pop_en  = 1'b1;
        pop_cls = CLS_LOW;
        lb_d    = 1'b0;
        nb_d    = NORMAL_BUDGET_FULL;
      end else if (not_empty[CLS_NORMAL]) begin
        pop_en  = 1'b1;
        pop_cls = CLS_NORMAL;
        nb_d    = NORMAL_BUDGET_ONE;
        lb_d    = LOW_BUDGET_ONE;
      end else if (not_empty[CLS_LOW]) begin
        pop_en  = 1'b1;
        pop_cls = CLS_LOW;
        lb_d    = LOW_BUDGET_ONE;
      end
    end
    op_ok = push_en || pop_en;
  end

  // Per-class storage, pointers and counts
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_fifo
    logic [JOB_WIDTH-1:0] mem_q [QUEUE_DEPTH];
    logic                 do_push, do_pop;

    assign do_push = fire && push_en && (cmd_i.cls == cls_e'(c));
    assign do_pop  = fire && pop_en  && (pop_cls == cls_e'(c));

    always_ff @(posedge clk_i) begin
      if (do_push) begin
        mem_q[tail_q[c]] <= cmd_i.job;
      end
      if (do_pop) begin
        rd_data_q[c] <= mem_q[head_q[c]];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        cnt_q[c]  <= '0;
      end else begin
        if (do_push) begin
          tail_q[c] <= (tail_q[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q[c] + 1'b1;
          cnt_q[c]  <= cnt_q[c] + 1'b1;
        end
        if (do_pop) begin
          head_q[c] <= (head_q[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[c] + 1'b1;
          cnt_q[c]  <= cnt_q[c] - 1'b1;
        end
      end
    end
  end

  // Budgets and result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q        <= NORMAL_BUDGET_FULL;
      lb_q        <= LOW_BUDGET_ONE;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        nb_q        <= nb_d;
        lb_q        <= lb_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_ok_q  <= op_ok;
      out_rd_q  <= pop_en;
      out_cls_q <= pop_cls;
    end
  end

  // Returned job comes straight from the registered FIFO read
  always_comb begin
    job_out_o = '0;
    if (out_rd_q) begin
      unique case (out_cls_q)
        CLS_HIGH:   job_out_o = JOB_PORT_W'(rd_data_q[CLS_HIGH]);
        CLS_NORMAL: job_out_o = JOB_PORT_W'(rd_data_q[CLS_NORMAL]);
        CLS_LOW:    job_out_o = JOB_PORT_W'(rd_data_q[CLS_LOW]);
        default:    job_out_o = '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[CLS_HIGH] <= CNT_W'(QUEUE_DEPTH)) && (cnt_q[CLS_NORMAL] <= CNT_W'(QUEUE_DEPTH))
    && (cnt_q[CLS_LOW] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_nb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nb_q <= NORMAL_BUDGET_FULL)
    else $error("normal budget out of range");

  a_high_keeps_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (cmd_i.op == OP_RECV) && not_empty[CLS_HIGH] |=> $stable(nb_q) && $stable(lb_q))
    else $error("high-class pop changed a budget");

  a_rd_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rd_q |-> out_ok_q)
    else $error("returned job without ok");

endmodule

`default_nettype wire

@@ rtl/core/three_class_forward_queue_scheduler.sv @@
// Path: an accepted transaction is held in the two-entry command queue of the front end, then
// the back end registers its result; a stall on the output can hold either step.
// Throughput: one enqueue or receive per cycle while the output is not stalled; the back end serves
// one command per cycle from the command queue; the FIFO read is registered into the result stage.
// Reset: asynchronous, active low; all queues empty, normal budget 2, low budget 1.
// FIFO contents are not cleared by reset; entries are only read after being written.
`default_nettype none

module three_class_forward_queue_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [1:0]  priority_req_i,
  input  wire logic [63:0] job_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic [63:0]      job_out_o
);
  import tcfqs_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Accept and classify
  tcfqs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .priority_req_i (priority_req_i),
    .job_in_i       (job_in_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  // Queues, arbitration and result
  tcfqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .job_out_o   (job_out_o)
  );

endmodule

`default_nettype wire

@@ bench/tcfqs_checker.sv @@
// Checker: watches both channels of the queue scheduler, predicts each result and compares.
`default_nettype none

module tcfqs_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic        mode_i,
  input  wire logic [1:0]  priority_req_i,
  input  wire logic [63:0] job_in_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        ok_i,
  input  wire logic [63:0] job_out_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               accepted_o,
  output int               checked_o,
  output int               drops_o,
  output int               misses_o
);
  import tcfqs_pkg::*;

  typedef struct packed {
    logic                  ok;
    logic [JOB_PORT_W-1:0] job;
  } sched_result_t;

  // Shadow copy of the scheduler state
  logic [JOB_WIDTH-1:0] high_jobs[$];
  logic [JOB_WIDTH-1:0] normal_jobs[$];
  logic [JOB_WIDTH-1:0] low_jobs[$];
  logic [1:0]           normal_credit;
  logic                 low_credit;

  // Results predicted but not yet seen on the output
  sched_result_t pending_results[$];

  // Apply one transaction to the shadow state and return its result
  function automatic sched_result_t predict_scheduler(input op_e op, input logic [1:0] prio,
                                                      input logic [63:0] job);
    sched_result_t res;
    cls_e          cls;
    res.ok  = 1'b0;
    res.job = '0;
    if (op == OP_ENQ) begin
      case (prio)
        PRIO_HIGH: cls = CLS_HIGH;
        PRIO_LOW:  cls = CLS_LOW;
        default:   cls = CLS_NORMAL;  // normal and the spare code
      endcase
      case (cls)
        CLS_HIGH: begin
          if (high_jobs.size() < QUEUE_DEPTH) begin
            high_jobs.push_back(job[JOB_WIDTH-1:0]);
            res.ok = 1'b1;
          end
        end
        CLS_LOW: begin
          if (low_jobs.size() < QUEUE_DEPTH) begin
            low_jobs.push_back(job[JOB_WIDTH-1:0]);
            res.ok = 1'b1;
          end
        end
        default: begin
          if (normal_jobs.size() < QUEUE_DEPTH) begin
            normal_jobs.push_back(job[JOB_WIDTH-1:0]);
            res.ok = 1'b1;
          end
        end
      endcase
      if (!res.ok) drops_o++;
    end else if (high_jobs.size() != 0) begin
      res.ok  = 1'b1;
      res.job = high_jobs.pop_front();
    end else if (normal_credit != 2'd0 && normal_jobs.size() != 0) begin
      // budgeted normal slot
      res.ok        = 1'b1;
      res.job       = normal_jobs.pop_front();
      normal_credit = normal_credit - 2'd1;
      low_credit    = LOW_BUDGET_ONE;
    end else if (low_credit && low_jobs.size() != 0) begin
      // budgeted low slot
      res.ok        = 1'b1;
      res.job       = low_jobs.pop_front();
      low_credit    = 1'b0;
      normal_credit = NORMAL_BUDGET_FULL;
    end else if (normal_jobs.size() != 0) begin
      // fallback: normal without budget
      res.ok        = 1'b1;
      res.job       = normal_jobs.pop_front();
      normal_credit = NORMAL_BUDGET_ONE;
      low_credit    = LOW_BUDGET_ONE;
    end else if (low_jobs.size() != 0) begin
      // fallback: low without budget
      res.ok     = 1'b1;
      res.job    = low_jobs.pop_front();
      low_credit = LOW_BUDGET_ONE;
    end else begin
      misses_o++;
    end
    return res;
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin : track
    sched_result_t want;
    if (!rst_ni) begin
      high_jobs.delete();
      normal_jobs.delete();
      low_jobs.delete();
      pending_results.delete();
      normal_credit = NORMAL_BUDGET_FULL;
      low_credit    = LOW_BUDGET_ONE;
      fail_count_o  = 0;
      pending_o     = 0;
      accepted_o    = 0;
      checked_o     = 0;
      drops_o       = 0;
      misses_o      = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(predict_scheduler(op_e'(mode_i), priority_req_i, job_in_i));
        accepted_o++;
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: ok %0b job %h", $time, ok_i, job_out_i);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          checked_o++;
          if (ok_i !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, ok_i);
            fail_count_o++;
          end
          if (job_out_i !== want.job) begin
            $display("%0t: job_out mismatch: expected %h, actual %h", $time, want.job,
                     job_out_i);
            fail_count_o++;
          end
        end
      end
      pending_o = pending_results.size();
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_three_class_forward_queue_scheduler.sv @@
// Testbench top: drives enqueue and receive traffic into the scheduler and reports the verdict.
`default_nettype none

module tb_three_class_forward_queue_scheduler;
  import tcfqs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 20;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        mode      = OP_ENQ;
  logic [1:0]  prio      = PRIO_HIGH;
  logic [63:0] job       = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [63:0] job_out;

  int fail_count, pending, accepted, checked, drops, misses;
  int cycle_count      = 0;
  int send_idle_odds   = 4;  // odds of one in this many of an idle burst before each item, 0 = none
  int recv_idle_odds   = 4;
  bit hold_req         = 1'b0;
  bit hold_done        = 1'b0;

  three_class_forward_queue_scheduler uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .priority_req_i (prio),
    .job_in_i       (job),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .ok_o           (ok),
    .job_out_o      (job_out)
  );

  tcfqs_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .mode_i         (mode),
    .priority_req_i (prio),
    .job_in_i       (job),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .ok_i           (ok),
    .job_out_i      (job_out),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .accepted_o     (accepted),
    .checked_o      (checked),
    .drops_o        (drops),
    .misses_o       (misses)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one transaction, with an optional idle burst first; returns at the next falling edge
  task automatic send_cmd(input op_e op, input logic [1:0] p, input logic [63:0] j);
    int gap;
    if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    prio     <= p;
    job      <= j;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Job words: mostly random, sometimes the extremes
  function automatic logic [63:0] pick_job();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random(input int enq_pct);
    op_e op;
    op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_RECV;
    send_cmd(op, 2'($urandom_range(0, 3)), pick_job());
  endtask

  // Output side: random stall bursts plus one long hold-off on request
  initial begin : receiver
    int burst;
    burst = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (burst > 0) begin
        out_ready <= 1'b0;
        burst--;
      end else if (recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 6) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty receive, every class code, then the arbitration paths
    send_cmd(OP_RECV, PRIO_HIGH, '0);
    send_cmd(OP_ENQ, PRIO_HIGH, '0);
    send_cmd(OP_ENQ, PRIO_NORMAL, '1);
    send_cmd(OP_ENQ, PRIO_ALT, 64'h0123_4567_89ab_cdef);
    send_cmd(OP_ENQ, PRIO_LOW, 64'hfedc_ba98_7654_3210);
    send_cmd(OP_ENQ, PRIO_LOW, 64'h5555_5555_5555_5555);
    send_cmd(OP_ENQ, PRIO_NORMAL, 64'haaaa_aaaa_aaaa_aaaa);
    repeat (6) send_cmd(OP_RECV, PRIO_LOW, '1);  // high, normal x2, low, normal, low
    // normal served past its budget while low is empty
    repeat (3) send_cmd(OP_ENQ, PRIO_NORMAL, pick_job());
    repeat (3) send_cmd(OP_RECV, PRIO_NORMAL, pick_job());
    // low served with its budget spent while normal is empty
    repeat (2) send_cmd(OP_ENQ, PRIO_LOW, pick_job());
    repeat (3) send_cmd(OP_RECV, PRIO_ALT, pick_job());

    // Random: balanced mix
    repeat (300) send_random(50);
    // Enqueue heavy, with the output held off to fill the pipe and the queues
    hold_req = 1'b1;
    repeat (200) send_random(85);
    // Receive heavy: drains, empty receives, budget fallbacks
    repeat (250) send_random(25);
    // No idling on either side
    send_idle_odds = 0;
    recv_idle_odds = 0;
    repeat (250) send_random(50);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions in, %0d results checked", accepted, checked);
    $display("enqueues refused on a full queue: %0d, receives with nothing queued: %0d",
             drops, misses);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
